>>> hw/rtl/dpid_pkg.sv
// Shared types and constants for the dual-polarization intensity decimator.
// No dependencies; imported by every module of the block.
package dpid_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;           // one signed sample component
  localparam int SQ_W     = 2 * SAMPLE_W - 1; // square of a 16-bit value, at most 2^30
  localparam int POW_W    = 2 * SAMPLE_W; // re^2 + im^2, at most 2^31
  localparam int RAD_W    = 2 * POW_W;    // Px^2 + Py^2, at most 2^63
  localparam int ROOT_W   = RAD_W / 2;    // integer square root
  localparam int REM_W    = ROOT_W + 2;   // partial remainder, at most 2*root
  localparam int ACC_W    = 40;           // group sum
  localparam int CFG_W    = 9;            // decimation factor register

  // One square-root cell per result bit
  localparam int SQRT_CELLS = ROOT_W;

  // Defaults
  localparam int unsigned DEF_MAX_FACTOR = 256;
  localparam logic [CFG_W-1:0] FACTOR_RESET = CFG_W'(1);

  // Data handed from one square-root cell to the next
  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, top aligned
    logic [REM_W-1:0]  rem;   // running remainder
    logic [ROOT_W-1:0] root;  // root bits found so far
    logic              eos;   // end of subband mark riding along
  } sqrt_bus_t;

  // Handshake status from the group accumulator back to the pipeline
  typedef struct packed {
    logic adv;    // whole pipeline may move this cycle
    logic emit;   // the sample at the accumulator closes a group
  } acc_stat_t;

endpackage

>>> hw/rtl/dpid_power.sv
// Front end: per-polarization power and the sum of squared powers.
// Four registered stages; uses dpid_pkg.
module dpid_power
  import dpid_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] x_real,
  input  logic signed [SAMPLE_W-1:0] x_imag,
  input  logic signed [SAMPLE_W-1:0] y_real,
  input  logic signed [SAMPLE_W-1:0] y_imag,
  input  logic                       in_eos,
  output logic                       out_valid,
  output sqrt_bus_t                  out_bus
);

  logic signed [2*SAMPLE_W-1:0] p_xr, p_xi, p_yr, p_yi;
  logic [SQ_W-1:0]  sq_xr_r, sq_xi_r, sq_yr_r, sq_yi_r;
  logic [POW_W-1:0] px_r, py_r;
  logic [RAD_W-1:0] pxx_r, pyy_r, rad_r;
  logic [3:0]       vld_r, vld_nxt;
  logic [3:0]       eos_r;

  // Squares of the four components; each fits below bit SQ_W
  assign p_xr = x_real * x_real;
  assign p_xi = x_imag * x_imag;
  assign p_yr = y_real * y_real;
  assign p_yi = y_imag * y_imag;

  // Advance the valid marks together with the data
  assign vld_nxt = {vld_r[2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Datapath stages: squares, powers, squared powers, radicand
  always_ff @(posedge clk) begin
    if (en) begin
      sq_xr_r <= p_xr[SQ_W-1:0];
      sq_xi_r <= p_xi[SQ_W-1:0];
      sq_yr_r <= p_yr[SQ_W-1:0];
      sq_yi_r <= p_yi[SQ_W-1:0];
      px_r    <= POW_W'(sq_xr_r) + POW_W'(sq_xi_r);
      py_r    <= POW_W'(sq_yr_r) + POW_W'(sq_yi_r);
      pxx_r   <= px_r * px_r;
      pyy_r   <= py_r * py_r;
      rad_r   <= pxx_r + pyy_r;
      eos_r   <= {eos_r[2:0], in_eos};
    end
  end

  assign out_valid    = vld_r[3];
  assign out_bus.rad  = rad_r;
  assign out_bus.rem  = '0;
  assign out_bus.root = '0;
  assign out_bus.eos  = eos_r[3];

endmodule

>>> hw/rtl/dpid_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit from two radicand bits.
// Uses dpid_pkg for the bus between cells.
module dpid_sqrt_cell
  import dpid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  sqrt_bus_t in_bus,
  output logic      out_valid,
  output sqrt_bus_t out_bus
);

  localparam int TW = REM_W + 2;

  logic [TW-1:0] rem_sh, trial, diff;
  logic          take;
  sqrt_bus_t     bus_r, bus_nxt;
  logic          vld_r;

  // Bring down the next two radicand bits and try root*4+1
  assign rem_sh = {in_bus.rem, in_bus.rad[RAD_W-1 -: 2]};
  assign trial  = TW'({in_bus.root, 2'b01});
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_comb begin
    bus_nxt      = in_bus;
    bus_nxt.rad  = in_bus.rad << 2;
    bus_nxt.rem  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    bus_nxt.root = {in_bus.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_bus   = bus_r;

endmodule

>>> hw/rtl/dpid_accum.sv
// Group accumulator, sample counter and output register.
// Uses dpid_pkg; drives the pipeline advance signal.
module dpid_accum
  import dpid_pkg::*;
#(
  parameter int unsigned MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  logic              in_eos,
  input  logic [CFG_W-1:0]  factor,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [ACC_W-1:0]  out_tdata,
  output acc_stat_t         stat
);

  localparam int CNT_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int CMP_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

  logic [ACC_W-1:0] acc_r, acc_nxt, sum;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CMP_W-1:0] cfg_ext, f_eff, cnt_inc;
  logic             close, emit, adv;
  logic             out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0] out_data_r, out_data_nxt;

  // Effective factor: zero acts as one, clamp to the maximum
  assign cfg_ext = CMP_W'(factor);
  always_comb begin
    if (factor == '0) begin
      f_eff = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FACTOR)) begin
      f_eff = CMP_W'(MAX_FACTOR);
    end else begin
      f_eff = cfg_ext;
    end
  end

  assign cnt_inc = CMP_W'(cnt_r) + CMP_W'(1);
  assign close   = cnt_inc >= f_eff;
  assign emit    = in_valid && close;
  assign sum     = acc_r + ACC_W'(in_root);

  // Hold the pipeline only when a closing sample meets an untaken result
  assign adv       = !(out_valid_r && !out_tready && emit);
  assign stat.adv  = adv;
  assign stat.emit = emit;

  // Accumulate, close the group, drop a partial group at end of subband
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (in_valid && adv) begin
      if (close) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = sum;
        cnt_nxt = cnt_inc[CNT_W-1:0];
      end
      if (in_eos) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end
    end
  end

  // Output register: load on a closing sample, release when taken
  always_comb begin
    out_data_nxt = out_data_r;
    if (emit && adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sum;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/dual_pol_intensity_decimator_unit.sv
// Dual-polarization intensity decimator, top level.
// Depends on dpid_pkg, dpid_power, dpid_sqrt_cell and dpid_accum.
//
// Takes one dual-pol sample per cycle while in_tready is high and sums
// floor(sqrt(Px^2 + Py^2)) over groups of decimation_factor samples, emitting
// one 40-bit sum per group. Each sample passes four power stages and a row of
// 32 square-root cells, one root bit each, on its way to the group
// accumulator, and a closing sum is registered in the output register that
// drives out_tdata. in_tready drops only while the output register holds an
// untaken sum and the sample leaving the last cell closes another group.
// tlast on the input ends the subband and drops a partial group. Write
// cfg_wr_data only while the block is empty; a value of zero acts as one and
// a value above MAX_FACTOR acts as MAX_FACTOR. No clearing pass is needed
// after reset.
module dual_pol_intensity_decimator_unit
  import dpid_pkg::*;
#(
  parameter int unsigned MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input samples
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [4*SAMPLE_W-1:0]     in_tdata,   // x_real, x_imag, y_real, y_imag
  input  logic                      in_tlast,   // end_of_subband
  // Group sums
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ACC_W-1:0]          out_tdata,  // intensity_sum
  // Decimation factor register
  input  logic                      cfg_wr_en,
  input  logic [CFG_W-1:0]          cfg_wr_data
);

  logic [CFG_W-1:0] factor_r, factor_nxt;
  acc_stat_t        stat;
  logic             in_acc;
  logic             cell_vld [0:SQRT_CELLS];
  sqrt_bus_t        cell_bus [0:SQRT_CELLS];

  // Factor register
  assign factor_nxt = cfg_wr_en ? cfg_wr_data : factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else begin
      factor_r <= factor_nxt;
    end
  end

  assign in_tready = stat.adv;
  assign in_acc    = in_tvalid && stat.adv;

  // Powers and radicand
  dpid_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (stat.adv),
    .in_valid  (in_acc),
    .x_real    (in_tdata[SAMPLE_W-1:0]),
    .x_imag    (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .y_real    (in_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .y_imag    (in_tdata[4*SAMPLE_W-1:3*SAMPLE_W]),
    .in_eos    (in_tlast),
    .out_valid (cell_vld[0]),
    .out_bus   (cell_bus[0])
  );

  // Row of square-root cells, most significant root bit first
  for (genvar gi = 0; gi < SQRT_CELLS; gi++) begin : g_cell
    dpid_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (stat.adv),
      .in_valid  (cell_vld[gi]),
      .in_bus    (cell_bus[gi]),
      .out_valid (cell_vld[gi+1]),
      .out_bus   (cell_bus[gi+1])
    );
  end

  // Group sums
  dpid_accum #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cell_vld[SQRT_CELLS]),
    .in_root    (cell_bus[SQRT_CELLS].root),
    .in_eos     (cell_bus[SQRT_CELLS].eos),
    .factor     (factor_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

endmodule

>>> hw/rtl/dpid_checker.sv
// Port-level checks for the intensity decimator, bound to the top level.
// Uses dpid_pkg for widths.
module dpid_checker
  import dpid_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [ACC_W-1:0] out_tdata
);

  // No result may appear right after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Input backpressure only comes from an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

  // Held result keeps its request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result request dropped before taken");

  // Held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while waiting");

endmodule

bind dual_pol_intensity_decimator_unit dpid_checker u_dpid_checker (.*);

>>> verif/dual_pol_intensity_decimator_unit_test.sv
// Self-checking bench for dual_pol_intensity_decimator_unit: a directed table,
// then random phases at several decimation factors. Depends on dpid_pkg and the
// block's RTL only; every sum is checked against a prediction made in here.
module dual_pol_intensity_decimator_unit_test;
  import dpid_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no request moved
  localparam int unsigned DRAIN_CYCLES = 48;    // pipeline is 37 deep
  localparam int unsigned HOLD_CYCLES  = 220;   // long receiver hold-off
  localparam int unsigned FACTOR_CAP   = DEF_MAX_FACTOR;
  localparam int unsigned REPORT_MAX   = 10;

  // One row of the directed table; an optional register write goes first
  typedef struct {
    bit                 write_first;
    logic [CFG_W-1:0]   factor;
    logic [SAMPLE_W-1:0] xr, xi, yr, yi;
    bit                 last;
    bit                 typed;
    logic [ACC_W-1:0]   sum;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [4*SAMPLE_W-1:0] in_tdata = '0;   // x_real, x_imag, y_real, y_imag
  logic                  in_tlast = 1'b0; // end_of_subband
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [ACC_W-1:0]      out_tdata;       // intensity_sum
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  // Predictor state
  logic [CFG_W-1:0]      shadow_factor;
  logic [ACC_W-1:0]      group_sum;
  int unsigned           group_len;
  logic [ACC_W-1:0]      pending_sums[$];

  table_row_t            directed_rows[$];
  int unsigned           fail_count = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           hold_requests = 0;
  int unsigned           holds_served = 0;
  bit                    no_gaps = 1'b0;

  dual_pol_intensity_decimator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Power of one polarization: re^2 + im^2, at most 2^31
  function automatic logic [POW_W-1:0] pol_energy(input logic [SAMPLE_W-1:0] re,
                                                  input logic [SAMPLE_W-1:0] im);
    longint a;
    longint b;
    a = longint'($signed(re));
    b = longint'($signed(im));
    return POW_W'(a * a + b * b);
  endfunction

  // Floor square root, one result bit per pass
  function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] v);
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] res;
    logic [RAD_W-1:0] probe;
    rem   = v;
    res   = '0;
    probe = RAD_W'(1) << (RAD_W - 2);
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res[ROOT_W-1:0];
  endfunction

  function automatic logic [ROOT_W-1:0] intensity_of(input logic [4*SAMPLE_W-1:0] d);
    logic [RAD_W-1:0] px;
    logic [RAD_W-1:0] py;
    px = RAD_W'(pol_energy(d[15:0], d[31:16]));
    py = RAD_W'(pol_energy(d[47:32], d[63:48]));
    return floor_root(px * px + py * py);
  endfunction

  // Add one sample to the running group; report a closing sum
  task automatic fold_into_group(input logic [4*SAMPLE_W-1:0] d, input bit last,
                                 output bit closes, output logic [ACC_W-1:0] sum);
    int unsigned f;
    f = 32'(shadow_factor);
    if (f == 0) f = 1;
    if (f > FACTOR_CAP) f = FACTOR_CAP;
    group_sum = group_sum + ACC_W'(intensity_of(d));
    closes = (group_len + 1 >= f);
    sum    = group_sum;
    if (closes) begin
      group_sum = '0;
      group_len = 0;
    end else begin
      group_len++;
    end
    // End of subband drops whatever is left
    if (last) begin
      group_sum = '0;
      group_len = 0;
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample component: extremes, small values of either sign, or anything
  function automatic logic [SAMPLE_W-1:0] pick_component();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one sample until taken, then predict its result
  task automatic offer_sample(input logic [4*SAMPLE_W-1:0] d, input bit last,
                              input bit typed, input logic [ACC_W-1:0] typed_sum);
    bit               closes;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] expect_sum;
    int unsigned      gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_into_group(d, last, closes, sum);
    expect_sum = typed ? typed_sum : sum;
    if (closes) pending_sums = {pending_sums, expect_sum};
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the block, then write the factor register
  task automatic write_factor(input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= value;
    shadow_factor = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_row(input bit write_first, input logic [CFG_W-1:0] factor,
                         input logic [SAMPLE_W-1:0] xr, input logic [SAMPLE_W-1:0] xi,
                         input logic [SAMPLE_W-1:0] yr, input logic [SAMPLE_W-1:0] yi,
                         input bit last, input bit typed, input logic [ACC_W-1:0] sum);
    table_row_t r;
    r.write_first = write_first;
    r.factor      = factor;
    r.xr          = xr;
    r.xi          = xi;
    r.yr          = yr;
    r.yi          = yi;
    r.last        = last;
    r.typed       = typed;
    r.sum         = sum;
    directed_rows = {directed_rows, r};
  endtask

  // Receiver: random readiness, plus one long hold-off on request
  initial begin : sink
    int unsigned gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Compare each taken sum with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        fail_count++;
        if (mismatch_count < REPORT_MAX)
          $display("unexpected sum %0d with nothing predicted", out_tdata);
        mismatch_count++;
      end else begin
        if (out_tdata !== pending_sums[0]) begin
          fail_count++;
          if (mismatch_count < REPORT_MAX)
            $display("intensity_sum mismatch: expected %0d, got %0d",
                     pending_sums[0], out_tdata);
          mismatch_count++;
        end
        void'(pending_sums.pop_front());
      end
    end
  end

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[dual_pol_intensity_decimator_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      ph;
    int unsigned      n;
    int unsigned      count;
    int unsigned      tlast_odds;
    logic [CFG_W-1:0] f;
    table_row_t       r;

    shadow_factor = FACTOR_RESET;
    group_sum     = '0;
    group_len     = 0;

    // Directed table; sums typed in only where factor one makes them obvious
    add_row(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1, 40'd0);
    add_row(0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 1, 40'd3037000499);
    add_row(0, 0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 0, 1, 40'd1073741824);
    add_row(0, 0, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 0, 1, 40'd1073676289);
    add_row(0, 0, 16'h0003, 16'h0004, 16'h0000, 16'h0000, 0, 1, 40'd25);
    // end of subband on a completing sample
    add_row(0, 0, 16'h0000, 16'h0000, 16'hfffd, 16'h0004, 1, 1, 40'd25);
    add_row(0, 0, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 0, 1, 40'd2);
    add_row(0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 1, 40'd2);
    add_row(0, 0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 0, 0, '0);
    add_row(0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, '0);
    // factor zero acts as one
    add_row(1, 9'd0, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 0, 1, 40'd1);
    add_row(1, 9'd3, 16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 0, 0, '0);
    add_row(0, 0, 16'h0f0f, 16'hf0f0, 16'h3c3c, 16'hc3c3, 0, 0, '0);
    add_row(0, 0, 16'h8000, 16'h7fff, 16'h0001, 16'hfffe, 0, 0, '0);
    // partial group dropped at end of subband
    add_row(0, 0, 16'h4000, 16'h2000, 16'h1000, 16'h0800, 0, 0, '0);
    add_row(0, 0, 16'h0400, 16'h0200, 16'h0100, 16'h0080, 1, 0, '0);
    // factor lowered mid-group: next sample closes the group
    add_row(0, 0, 16'h0040, 16'h0020, 16'h0010, 16'h0008, 0, 0, '0);
    add_row(0, 0, 16'h7ffe, 16'h8001, 16'hc000, 16'h3fff, 0, 0, '0);
    add_row(1, 9'd2, 16'h0004, 16'h0002, 16'h0001, 16'hffff, 0, 0, '0);
    // factor above the cap acts as the cap
    add_row(1, 9'd300, 16'ha5a5, 16'h5a5a, 16'h0000, 16'hffff, 0, 0, '0);
    add_row(0, 0, 16'h6666, 16'h9999, 16'hfff0, 16'h000f, 0, 0, '0);

    // Hold reset, then release it
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.write_first) write_factor(r.factor);
      offer_sample({r.yi, r.yr, r.xi, r.xr}, r.last, r.typed, r.sum);
    end

    // Random phases; the group left open by each phase carries into the next
    for (ph = 0; ph < 12; ph++) begin
      tlast_odds = 10;
      no_gaps    = ($urandom_range(0, 3) == 0);
      case (ph)
        1: begin
          f = 9'd1; count = 80; no_gaps = 1'b1;
        end
        3: begin
          f = 9'd256; count = 300; tlast_odds = 0;
        end
        6: begin
          f = 9'd511; count = 270; tlast_odds = 0;
        end
        8: begin
          f = 9'd0; count = 40;
        end
        default: begin
          f = ($urandom_range(0, 9) < 7) ? CFG_W'($urandom_range(2, 9))
                                        : CFG_W'($urandom_range(10, 40));
          count = 45;
        end
      endcase
      write_factor(f);
      // Stall the receiver while the sender keeps offering samples
      if (ph == 1) hold_requests++;
      for (n = 0; n < count; n++)
        offer_sample({pick_component(), pick_component(), pick_component(),
                      pick_component()},
                     (tlast_odds != 0) && ($urandom_range(1, tlast_odds) == 1),
                     1'b0, '0);
    end

    // Let every predicted sum come out, then settle
    in_tvalid <= 1'b0;
    no_gaps   = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_sums.size() == 0) begin
      $display("[dual_pol_intensity_decimator_unit] OK");
    end else begin
      $display("[dual_pol_intensity_decimator_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dpid_pkg.sv
hw/rtl/dpid_power.sv
hw/rtl/dpid_sqrt_cell.sv
hw/rtl/dpid_accum.sv
hw/rtl/dual_pol_intensity_decimator_unit.sv
hw/rtl/dpid_checker.sv
verif/dual_pol_intensity_decimator_unit_test.sv
